FILE: design/max_heap_priority_queue_defines.svh
// Assertion macros shared by the max-heap priority queue RTL.
`ifndef MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`ifndef ASSERT_OFF
`define MHPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MHPQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MHPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define MHPQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

FILE: design/mhpq_pkg.sv
// Types, constants and codes of the max-heap priority queue.
`timescale 1ns / 1ps
package mhpq_pkg;

	localparam int CAPACITY = 1024;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = ADDR_W + 1;
	localparam int KEY_W    = 32;
	localparam int POS_W    = 10;
	localparam int OCNT_W   = 11;

	typedef logic [ADDR_W-1:0]       addr_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic [CNT_W:0]          child_t;
	typedef logic signed [KEY_W-1:0] key_t;

	typedef enum logic [1:0] {
		REQ_INSERT  = 2'd0,
		REQ_EXTRACT = 2'd1,
		REQ_DELETE  = 2'd2,
		REQ_CHANGE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BADIDX = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_LOAD,
		S_ENTER,
		S_UP_CMP,
		S_DN_L,
		S_DN_R,
		S_DN_CMP,
		S_WRITE,
		S_RESP
	} state_t;

	typedef enum logic [2:0] {
		RD_LAST,
		RD_PARENT,
		RD_GPARENT,
		RD_LEFT,
		RD_RIGHT,
		RD_NEXT_LEFT
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_HOLE,
		WR_PARENT,
		WR_CHILD
	} wr_sel_t;

	typedef enum logic [2:0] {
		IDX_KEEP,
		IDX_COUNT,
		IDX_ZERO,
		IDX_POS,
		IDX_PARENT,
		IDX_CHILD
	} idx_src_t;

	typedef enum logic [1:0] {
		CNT_KEEP,
		CNT_INC,
		CNT_DEC
	} cnt_op_t;

	typedef struct packed {
		logic     accept;
		logic     rd_en;
		rd_sel_t  rd_sel;
		wr_sel_t  wr_sel;
		idx_src_t idx_src;
		cnt_op_t  cnt_op;
		logic     take_top;
		logic     load_v;
		logic     cap_l;
		logic     set_status;
		status_t  status;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		req_t req;
		logic full;
		logic empty;
		logic bad_pos;
		logic last_pos;
		logic count_one;
		logic idx_zero;
		logic parent_zero;
		logic left_ok;
		logic right_ok;
		logic up_move;
		logic dn_move;
		logic next_left_ok;
	} dp_stat_t;

endpackage

FILE: design/mhpq_dp.sv
// Datapath of the max-heap priority queue: heap memory, hole registers, result register.
`timescale 1ns / 1ps
`include "max_heap_priority_queue_defines.svh"
module mhpq_dp import mhpq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_stat_t          stat,
	input  req_t              req_in,
	input  key_t              key_in,
	input  logic [POS_W-1:0]  pos_in,
	output status_t           res_status,
	output key_t              res_removed,
	output key_t              res_top,
	output logic [OCNT_W-1:0] res_count
);

	key_t             mem [CAPACITY];
	key_t             rdata_q;
	cnt_t             count_q;
	addr_t            idx_q;
	key_t             v_q;
	key_t             cval_q;
	key_t             top_q;
	key_t             removed_q;
	status_t          status_q;
	req_t             req_q;
	logic [POS_W-1:0] pos_q;

	status_t           res_status_q;
	key_t              res_removed_q;
	key_t              res_top_q;
	logic [OCNT_W-1:0] res_count_q;

	addr_t  parent, gparent, c_idx, raddr;
	cnt_t   cnt_m1;
	child_t left, right, next_left;
	logic   pick_r, we;
	key_t   c_val, wdata;

	always_comb begin
		parent    = (idx_q - ADDR_W'(1)) >> 1;
		gparent   = (parent - ADDR_W'(1)) >> 1;
		cnt_m1    = count_q - CNT_W'(1);
		left      = {1'b0, idx_q, 1'b1};
		right     = left + child_t'(1);
		pick_r    = (right < {1'b0, count_q}) && (rdata_q > cval_q);
		c_idx     = pick_r ? right[ADDR_W-1:0] : left[ADDR_W-1:0];
		c_val     = pick_r ? rdata_q : cval_q;
		next_left = {1'b0, c_idx, 1'b1};
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_LAST:      raddr = cnt_m1[ADDR_W-1:0];
			RD_PARENT:    raddr = parent;
			RD_GPARENT:   raddr = gparent;
			RD_LEFT:      raddr = left[ADDR_W-1:0];
			RD_RIGHT:     raddr = right[ADDR_W-1:0];
			RD_NEXT_LEFT: raddr = next_left[ADDR_W-1:0];
			default:      raddr = '0;
		endcase
	end

	always_comb begin
		we = (cmd.wr_sel != WR_NONE);
		case (cmd.wr_sel)
			WR_PARENT: wdata = rdata_q;
			WR_CHILD:  wdata = c_val;
			default:   wdata = v_q;
		endcase
	end

	// heap memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[idx_q] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (cmd.cnt_op)
				CNT_INC: count_q <= count_q + CNT_W'(1);
				CNT_DEC: count_q <= cnt_m1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q     <= req_in;
			v_q       <= key_in;
			pos_q     <= pos_in;
			status_q  <= ST_OK;
			removed_q <= '0;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status;
		end
		if (cmd.take_top) begin
			removed_q <= top_q;
		end
		if (cmd.load_v) begin
			v_q <= rdata_q;
		end
		if (cmd.cap_l) begin
			cval_q <= rdata_q;
		end
		if (we && idx_q == '0) begin
			top_q <= wdata;
		end
		case (cmd.idx_src)
			IDX_COUNT:  idx_q <= count_q[ADDR_W-1:0];
			IDX_ZERO:   idx_q <= '0;
			IDX_POS:    idx_q <= ADDR_W'(pos_q);
			IDX_PARENT: idx_q <= parent;
			IDX_CHILD:  idx_q <= c_idx;
			default:    idx_q <= idx_q;
		endcase
		if (cmd.out_load) begin
			res_status_q  <= status_q;
			res_removed_q <= removed_q;
			res_top_q     <= (count_q == '0) ? key_t'(0) : top_q;
			res_count_q   <= OCNT_W'(count_q);
		end
	end

	always_comb begin
		stat.req          = req_q;
		stat.full         = (count_q == CNT_W'(CAPACITY));
		stat.empty        = (count_q == '0);
		stat.bad_pos      = (CNT_W'(pos_q) >= count_q);
		stat.last_pos     = (CNT_W'(pos_q) == cnt_m1);
		stat.count_one    = (count_q == CNT_W'(1));
		stat.idx_zero     = (idx_q == '0);
		stat.parent_zero  = (parent == '0);
		stat.left_ok      = (left < {1'b0, count_q});
		stat.right_ok     = (right < {1'b0, count_q});
		stat.up_move      = (v_q > rdata_q);
		stat.dn_move      = (c_val > v_q);
		stat.next_left_ok = (next_left < {1'b0, count_q});
	end

	assign res_status  = res_status_q;
	assign res_removed = res_removed_q;
	assign res_top     = res_top_q;
	assign res_count   = res_count_q;

	`MHPQ_ASSERT(a_count_cap, clk, arst_n, count_q <= CNT_W'(CAPACITY), "count above capacity")
	`MHPQ_ASSERT(a_top_track, clk, arst_n, (we && idx_q == '0) |=> (top_q == $past(wdata)), "root copy stale")
	`MHPQ_ASSERT_NEVER(a_up_root, clk, arst_n, (cmd.wr_sel == WR_PARENT) && (idx_q == '0), "sift-up past root")

endmodule

FILE: design/mhpq_ctrl.sv
// Sequencer of the max-heap priority queue: request check, sift-up, sift-down, result handoff.
`timescale 1ns / 1ps
`include "max_heap_priority_queue_defines.svh"
module mhpq_ctrl import mhpq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q, state_d;
	logic   first_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_CHECK;
			end
			S_CHECK: begin
				case (stat.req)
					REQ_INSERT:  state_d = stat.full ? S_RESP : S_ENTER;
					REQ_EXTRACT: state_d = (stat.empty || stat.count_one) ? S_RESP : S_LOAD;
					REQ_DELETE:  state_d = (stat.bad_pos || stat.last_pos) ? S_RESP : S_LOAD;
					REQ_CHANGE:  state_d = stat.bad_pos ? S_RESP : S_ENTER;
					default:     state_d = S_RESP;
				endcase
			end
			S_LOAD:  state_d = S_ENTER;
			S_ENTER: state_d = stat.idx_zero ? S_DN_L : S_UP_CMP;
			S_UP_CMP: begin
				if (stat.up_move) begin
					state_d = stat.parent_zero ? S_WRITE : S_UP_CMP;
				end else begin
					state_d = first_q ? S_DN_L : S_WRITE;
				end
			end
			S_DN_L:  state_d = stat.left_ok ? S_DN_R : S_RESP;
			S_DN_R:  state_d = S_DN_CMP;
			S_DN_CMP: begin
				if (stat.dn_move) begin
					state_d = stat.next_left_ok ? S_DN_R : S_WRITE;
				end else begin
					state_d = S_RESP;
				end
			end
			S_WRITE: state_d = S_RESP;
			S_RESP: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.rd_sel = RD_LAST;
		cmd.wr_sel = WR_NONE;
		cmd.idx_src = IDX_KEEP;
		cmd.cnt_op = CNT_KEEP;
		cmd.status = ST_OK;
		case (state_q)
			S_IDLE: begin
				cmd.accept = in_valid;
			end
			S_CHECK: begin
				case (stat.req)
					REQ_INSERT: begin
						if (stat.full) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_FULL;
						end else begin
							cmd.idx_src = IDX_COUNT;
							cmd.cnt_op  = CNT_INC;
						end
					end
					REQ_EXTRACT: begin
						if (stat.empty) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_EMPTY;
						end else begin
							cmd.take_top = 1'b1;
							cmd.cnt_op   = CNT_DEC;
							cmd.idx_src  = IDX_ZERO;
							cmd.rd_en    = 1'b1;
							cmd.rd_sel   = RD_LAST;
						end
					end
					REQ_DELETE: begin
						if (stat.bad_pos) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_BADIDX;
						end else begin
							cmd.cnt_op  = CNT_DEC;
							cmd.idx_src = IDX_POS;
							cmd.rd_en   = 1'b1;
							cmd.rd_sel  = RD_LAST;
						end
					end
					REQ_CHANGE: begin
						if (stat.bad_pos) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_BADIDX;
						end else begin
							cmd.idx_src = IDX_POS;
						end
					end
					default: ;
				endcase
			end
			S_LOAD: begin
				cmd.load_v = 1'b1;
			end
			S_ENTER: begin
				if (!stat.idx_zero) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PARENT;
				end
			end
			S_UP_CMP: begin
				if (stat.up_move) begin
					cmd.wr_sel  = WR_PARENT;
					cmd.idx_src = IDX_PARENT;
					if (!stat.parent_zero) begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RD_GPARENT;
					end
				end
			end
			S_DN_L: begin
				if (stat.left_ok) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_LEFT;
				end else begin
					cmd.wr_sel = WR_HOLE;
				end
			end
			S_DN_R: begin
				cmd.cap_l = 1'b1;
				if (stat.right_ok) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_RIGHT;
				end
			end
			S_DN_CMP: begin
				if (stat.dn_move) begin
					cmd.wr_sel  = WR_CHILD;
					cmd.idx_src = IDX_CHILD;
					if (stat.next_left_ok) begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RD_NEXT_LEFT;
					end
				end else begin
					cmd.wr_sel = WR_HOLE;
				end
			end
			S_WRITE: begin
				cmd.wr_sel = WR_HOLE;
			end
			S_RESP: begin
				cmd.out_load = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// the first sift-up step may fall through to sift-down
			if (state_q == S_CHECK) begin
				first_q <= 1'b1;
			end else if (state_q == S_UP_CMP) begin
				first_q <= 1'b0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`MHPQ_ASSERT(a_accept_check, clk, arst_n, (in_valid && in_ready) |=> (state_q == S_CHECK), "accept lost")
	`MHPQ_ASSERT(a_load_free, clk, arst_n, cmd.out_load |-> (!out_valid_q || out_ready), "result overwritten")
	`MHPQ_ASSERT(a_dn_order, clk, arst_n, (state_q == S_DN_CMP) |-> ($past(state_q) == S_DN_R), "child compare out of order")

endmodule

FILE: design/max_heap_priority_queue.sv
// Top level of the binary max-heap priority queue with stream request and result ports.
// A refused request or a dropped last entry goes from the check straight to the result. An
// extract loads the last entry, then sifts down, per level reading the left child, then the
// right (both child reads share one memory port); then the hole and the result are written.
// One request at a time; a result still held stalls the next.
// arst_n clears the element count, the sequencer and the result valid; memory holds no reset.
`timescale 1ns / 1ps
module max_heap_priority_queue import mhpq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // req_type[1:0], key_value[33:2], position[43:34], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata   // status[1:0], removed_value[33:2], top_value[65:34],
	                              // element_count[76:66], zero pad
);

	dp_cmd_t           cmd;
	dp_stat_t          stat;
	status_t           res_status;
	key_t              res_removed;
	key_t              res_top;
	logic [OCNT_W-1:0] res_count;

	// sequencer: decides each request and walks the sift loop
	mhpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: heap memory, moving key, hole index and result register
	mhpq_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.req_in      (req_t'(s_tdata[1:0])),
		.key_in      ($signed(s_tdata[33:2])),
		.pos_in      (s_tdata[43:34]),
		.res_status  (res_status),
		.res_removed (res_removed),
		.res_top     (res_top),
		.res_count   (res_count)
	);

	// pack the result; pad the top bits with zeros
	assign m_tdata = {3'b000, res_count, res_top, res_removed, res_status};

endmodule

FILE: test/tb_top.sv
// Self-checking stream testbench for the max-heap priority queue.
`timescale 1ns / 1ps
module tb_top;
	import mhpq_pkg::*;

	// Consecutive cycles with no request or result accepted before the run is declared hung.
	// The slowest correct stretch is one sender wait, one full sift and one receiver stall.
	localparam int STALL_LIMIT   = 2000;
	// Cycles to keep watching for stray results once the last expected one has come.
	localparam int SETTLE_CYCLES = 40;
	localparam key_t KEY_MAX     = key_t'(32'h7fff_ffff);
	localparam key_t KEY_MIN     = key_t'(32'h8000_0000);

	typedef struct packed {
		req_t              op;
		key_t              key;
		logic [POS_W-1:0]  pos;
	} heap_req_t;

	typedef struct packed {
		status_t            status;
		key_t               removed;
		key_t               top;
		logic [OCNT_W-1:0]  count;
	} heap_rsp_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata  = '0;  // req_type[1:0], key_value[33:2], position[43:34], zero pad
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;        // status[1:0], removed_value[33:2], top_value[65:34],
	                             // element_count[76:66], zero pad

	heap_req_t req_pending [$];   // requests waiting to be driven
	heap_rsp_t rsp_expected [$];  // predicted results, oldest first
	heap_req_t req_on_bus;
	int        send_wait  = 0;
	int        send_calm  = 0;
	int        recv_wait  = 0;
	int        recv_calm  = 0;
	int        recv_draw;
	int        fail_count = 0;
	int        stall_cycles = 0;
	int        gen_fill   = 0;    // element count as seen by the request generator

	// Shadow heap used to predict each result.
	key_t heap_keys [CAPACITY];
	int   heap_fill = 0;

	max_heap_priority_queue u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void swap_keys(int a, int b);
		key_t t;
		t            = heap_keys[a];
		heap_keys[a] = heap_keys[b];
		heap_keys[b] = t;
	endfunction

	// Move an entry toward the root while it beats its parent.
	function automatic void bubble_up(int i);
		int  p;
		bit  done;
		done = 1'b0;
		while (!done && i > 0 && i < heap_fill) begin
			p = (i - 1) / 2;
			if (heap_keys[i] > heap_keys[p]) begin
				swap_keys(i, p);
				i = p;
			end else
				done = 1'b1;
		end
	endfunction

	// Move an entry toward the leaves while a child beats it.
	function automatic void sink_down(int i);
		int  l;
		int  r;
		int  big;
		bit  done;
		done = 1'b0;
		while (!done && i < heap_fill) begin
			l   = 2 * i + 1;
			r   = 2 * i + 2;
			big = i;
			if (l < heap_fill && heap_keys[l] > heap_keys[big])
				big = l;
			if (r < heap_fill && heap_keys[r] > heap_keys[big])
				big = r;
			if (big == i)
				done = 1'b1;
			else begin
				swap_keys(i, big);
				i = big;
			end
		end
	endfunction

	// Apply one request to the shadow heap and return the result it must produce.
	function automatic heap_rsp_t heap_apply(heap_req_t rq);
		heap_rsp_t rsp;
		key_t      prior;
		int        p;
		rsp.status  = ST_OK;
		rsp.removed = '0;
		p = int'(rq.pos);
		case (rq.op)
			REQ_INSERT: begin
				if (heap_fill >= CAPACITY)
					rsp.status = ST_FULL;
				else begin
					heap_keys[heap_fill] = rq.key;
					heap_fill++;
					bubble_up(heap_fill - 1);
				end
			end
			REQ_EXTRACT: begin
				if (heap_fill == 0)
					rsp.status = ST_EMPTY;
				else begin
					rsp.removed = heap_keys[0];
					heap_fill--;
					heap_keys[0] = heap_keys[heap_fill];
					sink_down(0);
				end
			end
			REQ_DELETE: begin
				if (p >= heap_fill)
					rsp.status = ST_BADIDX;
				else begin
					heap_fill--;
					heap_keys[p] = heap_keys[heap_fill];
					// dropping the last entry needs no repair
					if (p < heap_fill) begin
						if (p > 0 && heap_keys[p] > heap_keys[(p - 1) / 2])
							bubble_up(p);
						else
							sink_down(p);
					end
				end
			end
			default: begin
				if (p >= heap_fill)
					rsp.status = ST_BADIDX;
				else begin
					prior        = heap_keys[p];
					heap_keys[p] = rq.key;
					if (rq.key > prior)
						bubble_up(p);
					else if (prior > rq.key)
						sink_down(p);
				end
			end
		endcase
		rsp.top   = (heap_fill > 0) ? heap_keys[0] : '0;
		rsp.count = heap_fill[OCNT_W-1:0];
		return rsp;
	endfunction

	// Wait before the next handshake: usually a uniform random draw, with runs of back-to-back traffic.
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		return $urandom_range(0, 10);
	endfunction

	function automatic key_t rand_key();
		case ($urandom_range(0, 9))
			6, 7:    return key_t'($signed($urandom_range(0, 8)) - 4);
			8:       return $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
			default: return key_t'($urandom);
		endcase
	endfunction

	// Mostly a live index, sometimes anything the field can carry.
	function automatic logic [POS_W-1:0] rand_pos();
		if (gen_fill > 0 && $urandom_range(0, 99) < 85)
			return POS_W'($urandom_range(0, gen_fill - 1));
		return POS_W'($urandom_range(0, 1023));
	endfunction

	// Queue a request and track the element count it will leave behind.
	task automatic send_request(req_t op, key_t key, logic [POS_W-1:0] pos);
		heap_req_t rq;
		rq.op  = op;
		rq.key = key;
		rq.pos = pos;
		case (op)
			REQ_INSERT:  if (gen_fill < CAPACITY) gen_fill++;
			REQ_EXTRACT: if (gen_fill > 0) gen_fill--;
			REQ_DELETE:  if (int'(pos) < gen_fill) gen_fill--;
			default: ;
		endcase
		req_pending.insert(req_pending.size(), rq);
	endtask

	task automatic send_random(int insert_pct);
		int r;
		int rest;
		r    = $urandom_range(0, 99);
		rest = 100 - insert_pct;
		if (r < insert_pct)
			send_request(REQ_INSERT, rand_key(), rand_pos());
		else if (r < insert_pct + rest / 3)
			send_request(REQ_EXTRACT, rand_key(), rand_pos());
		else if (r < insert_pct + 2 * rest / 3)
			send_request(REQ_DELETE, rand_key(), rand_pos());
		else
			send_request(REQ_CHANGE, rand_key(), rand_pos());
	endtask

	// Hold until every request is driven and every predicted result has come back.
	task automatic wait_heap_idle();
		while (req_pending.size() != 0 || s_tvalid || rsp_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic compare_heap_result(logic [79:0] data);
		heap_rsp_t want;
		status_t   got_status;
		key_t      got_removed;
		key_t      got_top;
		logic [OCNT_W-1:0] got_count;
		got_status  = status_t'(data[1:0]);
		got_removed = data[33:2];
		got_top     = data[65:34];
		got_count   = data[76:66];
		if (rsp_expected.size() == 0) begin
			$display("%0t: unexpected result %h", $time, data);
			fail_count++;
			return;
		end
		want = rsp_expected.pop_front();
		if (got_status != want.status) begin
			$display("%0t: status expected %0d actual %0d", $time, want.status, got_status);
			fail_count++;
		end
		if (got_removed != want.removed) begin
			$display("%0t: removed_value expected %0d actual %0d", $time, want.removed,
				got_removed);
			fail_count++;
		end
		if (got_top != want.top) begin
			$display("%0t: top_value expected %0d actual %0d", $time, want.top, got_top);
			fail_count++;
		end
		if (got_count != want.count) begin
			$display("%0t: element_count expected %0d actual %0d", $time, want.count,
				got_count);
			fail_count++;
		end
	endtask

	// Request driver: predict on every accepted request, then present the next one
	// after its drawn wait.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid  <= 1'b0;
			s_tdata   <= '0;
			send_wait <= 0;
		end else begin
			if (s_tvalid && s_tready)
				rsp_expected.insert(rsp_expected.size(), heap_apply(req_on_bus));
			if (!s_tvalid || s_tready) begin
				if (send_wait > 0) begin
					s_tvalid  <= 1'b0;
					send_wait <= send_wait - 1;
				end else if (req_pending.size() != 0) begin
					req_on_bus = req_pending.pop_front();
					s_tdata   <= {4'b0, req_on_bus.pos, req_on_bus.key, req_on_bus.op};
					s_tvalid  <= 1'b1;
					send_wait <= draw_wait(send_calm);
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	// Result monitor: check each accepted result, then stall tready for a drawn wait.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			recv_wait <= 0;
		end else if (m_tvalid && m_tready) begin
			compare_heap_result(m_tdata);
			recv_draw = draw_wait(recv_calm);
			recv_wait <= recv_draw;
			m_tready  <= (recv_draw == 0);
		end else if (recv_wait > 0) begin
			recv_wait <= recv_wait - 1;
			m_tready  <= (recv_wait == 1);
		end else
			m_tready <= 1'b1;
	end

	// Watchdog: abort when neither side moves for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
			$display("Some tests failed");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Refusals on an empty heap.
		send_request(REQ_EXTRACT, KEY_MAX, '0);
		send_request(REQ_DELETE, KEY_MIN, '0);
		send_request(REQ_CHANGE, key_t'(-1), '1);
		// Change to an equal key: written, no sift.
		send_request(REQ_INSERT, KEY_MAX, '0);
		send_request(REQ_CHANGE, KEY_MAX, '0);
		send_request(REQ_INSERT, KEY_MIN, '0);
		send_request(REQ_INSERT, key_t'(0), '1);
		send_request(REQ_INSERT, key_t'(-1), '0);
		send_request(REQ_INSERT, key_t'(1), '0);
		send_request(REQ_INSERT, key_t'(100), '0);
		send_request(REQ_INSERT, key_t'(100), '0);
		// Drop the last entry, then the same index is out of range.
		send_request(REQ_DELETE, '0, POS_W'(6));
		send_request(REQ_DELETE, '0, POS_W'(6));
		send_request(REQ_DELETE, '1, POS_W'(1));
		send_request(REQ_CHANGE, KEY_MAX, POS_W'(2));
		send_request(REQ_CHANGE, KEY_MIN, POS_W'(0));
		send_request(REQ_EXTRACT, '0, '0);
		send_request(REQ_EXTRACT, '0, '0);
		send_request(REQ_DELETE, '0, '0);
		send_request(REQ_DELETE, '0, '1);
		wait_heap_idle();

		// Grow a small heap with mixed traffic.
		repeat (50) send_random(50);
		// Stop feeding until every result is back.
		wait_heap_idle();
		repeat (30) send_random(30);
		wait_heap_idle();

		// Fill to capacity, then knock on the full heap.
		while (gen_fill < CAPACITY) begin
			if ($urandom_range(0, 19) != 0)
				send_request(REQ_INSERT, rand_key(), rand_pos());
			else
				send_request(REQ_CHANGE, rand_key(), rand_pos());
		end
		repeat (3) send_request(REQ_INSERT, rand_key(), rand_pos());
		repeat (20) send_request(REQ_CHANGE, rand_key(), rand_pos());
		send_request(REQ_INSERT, KEY_MAX, '1);
		wait_heap_idle();

		// Drain part of the full heap through deep sift-downs.
		repeat (120) begin
			case ($urandom_range(0, 9))
				7, 8:    send_request(REQ_DELETE, rand_key(), rand_pos());
				9:       send_request(REQ_CHANGE, rand_key(), rand_pos());
				default: send_request(REQ_EXTRACT, rand_key(), rand_pos());
			endcase
		end
		repeat (30) send_random(45);
		wait_heap_idle();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (rsp_expected.size() != 0) begin
			$display("%0t: %0d expected results never came", $time, rsp_expected.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+design
design/mhpq_pkg.sv
design/mhpq_dp.sv
design/mhpq_ctrl.sv
design/max_heap_priority_queue.sv
test/tb_top.sv
